>>> hdl/fsa_pkg.sv
// shared types and constants of the first-fit segment allocator
`timescale 1ns / 1ps
`default_nettype none
package fsa_pkg;
   localparam int MAX_SEGMENTS = 16;
   localparam int OFFSET_BITS  = 16;
   localparam int LEN_BITS     = 16;
   localparam int IDX_BITS     = $clog2(MAX_SEGMENTS);
   localparam int CNT_BITS     = $clog2(MAX_SEGMENTS + 1);
   localparam int HEAP_BITS    = 16;
   localparam logic [HEAP_BITS-1:0] HEAP_RESET = 16'hFFFF;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE  = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [LEN_BITS-1:0]    len;
      logic                   busy;
      logic [OFFSET_BITS-1:0] start;
   } entry_type;

   typedef struct packed {
      logic                wr_en;
      logic [IDX_BITS-1:0] wr_addr;
      entry_type           wr_data;
      logic [IDX_BITS-1:0] rd_addr;
   } tbl_req_type;
endpackage
`default_nettype wire

>>> hdl/fsa_table.sv
// segment table memory, one write and one registered read per cycle
`timescale 1ns / 1ps
`default_nettype none
module fsa_table (
   input  wire logic                clock,
   input  wire fsa_pkg::tbl_req_type tbl_req,
   output      fsa_pkg::entry_type  rd_data
);
   fsa_pkg::entry_type mem [fsa_pkg::MAX_SEGMENTS];

   always_ff @(posedge clock) begin
      if (tbl_req.wr_en) begin
         mem[tbl_req.wr_addr] <= tbl_req.wr_data;
      end
      rd_data <= mem[tbl_req.rd_addr];
   end
endmodule
`default_nettype wire

>>> hdl/fsa_seq.sv
// request sequencer: table scan, split, append, merge and compaction
`timescale 1ns / 1ps
`default_nettype none
module fsa_seq (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [fsa_pkg::HEAP_BITS-1:0]       heap_size,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic                                req_func,
   input  wire logic [15:0]                         req_alloc_size,
   input  wire logic [15:0]                         req_free_offset,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic [1:0]                          rsp_status,
   output      logic [15:0]                         rsp_granted_offset,
   output      fsa_pkg::tbl_req_type                tbl_req,
   input  wire fsa_pkg::entry_type                  rd_data
);
   localparam int OB = fsa_pkg::OFFSET_BITS;
   localparam int LB = fsa_pkg::LEN_BITS;
   localparam int CB = fsa_pkg::CNT_BITS;
   localparam int IB = fsa_pkg::IDX_BITS;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_SCAN_RD   = 4'd1;
   localparam logic [3:0] S_SCAN_EV   = 4'd2;
   localparam logic [3:0] S_SPLIT_RD  = 4'd3;
   localparam logic [3:0] S_SPLIT_WR  = 4'd4;
   localparam logic [3:0] S_SPLIT_REM = 4'd5;
   localparam logic [3:0] S_SPLIT_CUR = 4'd6;
   localparam logic [3:0] S_NEXT_EV   = 4'd7;
   localparam logic [3:0] S_SHD_RD    = 4'd8;
   localparam logic [3:0] S_SHD_WR    = 4'd9;
   localparam logic [3:0] S_DONE      = 4'd10;

   logic [3:0]        state_ff, state_in;
   logic [CB-1:0]     count_ff, count_in;
   logic [CB-1:0]     idx_ff, idx_in;
   logic [CB-1:0]     jdx_ff, jdx_in;
   logic [CB-1:0]     lo_ff, lo_in;
   logic [1:0]        dist_ff, dist_in;
   logic              func_ff, func_in;
   logic [15:0]       size_ff, size_in;
   logic [OB-1:0]     ofs_ff, ofs_in;
   logic [OB:0]       end_ff, end_in;
   fsa_pkg::entry_type cur_ff, cur_in;
   logic              prev_busy_ff, prev_busy_in;
   logic [LB-1:0]     prev_len_ff, prev_len_in;
   logic [OB-1:0]     prev_start_ff, prev_start_in;
   logic [LB-1:0]     sum_ff, sum_in;
   logic [OB-1:0]     lo_start_ff, lo_start_in;
   logic [1:0]        status_ff, status_in;
   logic [15:0]       granted_ff, granted_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [15:0]       rsp_granted_ff, rsp_granted_in;

   logic              table_full;
   logic              merge_next;
   logic [LB-1:0]     sum_next;
   logic [CB-1:0]     hi_next;
   logic [CB-1:0]     idx_inc;
   logic [OB+1:0]     append_end;

   assign table_full = (count_ff == CB'(fsa_pkg::MAX_SEGMENTS));
   assign idx_inc    = idx_ff + CB'(1);
   assign append_end = {1'b0, end_ff} + (OB+2)'(size_ff);
   assign merge_next = (idx_inc < count_ff) && !rd_data.busy;
   assign sum_next   = merge_next ? (sum_ff + rd_data.len) : sum_ff;
   assign hi_next    = merge_next ? idx_inc : idx_ff;

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_granted_offset = rsp_granted_ff;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      jdx_in         = jdx_ff;
      lo_in          = lo_ff;
      dist_in        = dist_ff;
      func_in        = func_ff;
      size_in        = size_ff;
      ofs_in         = ofs_ff;
      end_in         = end_ff;
      cur_in         = cur_ff;
      prev_busy_in   = prev_busy_ff;
      prev_len_in    = prev_len_ff;
      prev_start_in  = prev_start_ff;
      sum_in         = sum_ff;
      lo_start_in    = lo_start_ff;
      status_in      = status_ff;
      granted_in     = granted_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      tbl_req        = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in      = req_func;
               size_in      = req_alloc_size;
               ofs_in       = req_free_offset;
               idx_in       = '0;
               end_in       = '0;
               prev_busy_in = 1'b1;
               granted_in   = '0;
               status_in    = fsa_pkg::STATUS_OK;
               if (req_func == fsa_pkg::FUNC_ALLOC && req_alloc_size == '0) begin
                  status_in = fsa_pkg::STATUS_NO_SPACE;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_SCAN_RD: begin
            if (idx_ff == count_ff) begin
               state_in = S_DONE;
               if (func_ff == fsa_pkg::FUNC_ALLOC) begin
                  if (append_end > (OB+2)'(heap_size)) begin
                     status_in = fsa_pkg::STATUS_NO_SPACE;
                  end else if (table_full) begin
                     status_in = fsa_pkg::STATUS_FULL;
                  end else begin
                     tbl_req.wr_en         = 1'b1;
                     tbl_req.wr_addr       = count_ff[IB-1:0];
                     tbl_req.wr_data.len   = LB'(size_ff);
                     tbl_req.wr_data.busy  = 1'b1;
                     tbl_req.wr_data.start = end_ff[OB-1:0];
                     count_in              = count_ff + CB'(1);
                     granted_in            = 16'(end_ff[OB-1:0]);
                     status_in             = fsa_pkg::STATUS_OK;
                  end
               end else begin
                  status_in = fsa_pkg::STATUS_NOT_FOUND;
               end
            end else begin
               tbl_req.rd_addr = idx_ff[IB-1:0];
               state_in        = S_SCAN_EV;
            end
         end
         S_SCAN_EV: begin
            // prefetch the following entry for the merge check on free
            tbl_req.rd_addr = idx_inc[IB-1:0];
            end_in          = {1'b0, rd_data.start} + (OB+1)'(rd_data.len);
            if (func_ff == fsa_pkg::FUNC_ALLOC) begin
               if (!rd_data.busy && rd_data.len >= LB'(size_ff)) begin
                  if (rd_data.len == LB'(size_ff)) begin
                     tbl_req.wr_en         = 1'b1;
                     tbl_req.wr_addr       = idx_ff[IB-1:0];
                     tbl_req.wr_data       = rd_data;
                     tbl_req.wr_data.busy  = 1'b1;
                     granted_in            = 16'(rd_data.start);
                     status_in             = fsa_pkg::STATUS_OK;
                     state_in              = S_DONE;
                  end else if (table_full) begin
                     status_in = fsa_pkg::STATUS_FULL;
                     state_in  = S_DONE;
                  end else begin
                     cur_in   = rd_data;
                     jdx_in   = count_ff;
                     state_in = S_SPLIT_RD;
                  end
               end else begin
                  idx_in   = idx_inc;
                  state_in = S_SCAN_RD;
               end
            end else begin
               if (rd_data.start == ofs_ff) begin
                  if (!prev_busy_ff) begin
                     lo_in       = idx_ff - CB'(1);
                     lo_start_in = prev_start_ff;
                     sum_in      = prev_len_ff + rd_data.len;
                  end else begin
                     lo_in       = idx_ff;
                     lo_start_in = rd_data.start;
                     sum_in      = rd_data.len;
                  end
                  state_in = S_NEXT_EV;
               end else begin
                  prev_busy_in  = rd_data.busy;
                  prev_len_in   = rd_data.len;
                  prev_start_in = rd_data.start;
                  idx_in        = idx_inc;
                  state_in      = S_SCAN_RD;
               end
            end
         end
         S_SPLIT_RD: begin
            if (jdx_ff == idx_inc) begin
               state_in = S_SPLIT_REM;
            end else begin
               tbl_req.rd_addr = IB'(jdx_ff - CB'(1));
               state_in        = S_SPLIT_WR;
            end
         end
         S_SPLIT_WR: begin
            tbl_req.wr_en   = 1'b1;
            tbl_req.wr_addr = jdx_ff[IB-1:0];
            tbl_req.wr_data = rd_data;
            jdx_in          = jdx_ff - CB'(1);
            state_in        = S_SPLIT_RD;
         end
         S_SPLIT_REM: begin
            tbl_req.wr_en         = 1'b1;
            tbl_req.wr_addr       = idx_inc[IB-1:0];
            tbl_req.wr_data.len   = cur_ff.len - LB'(size_ff);
            tbl_req.wr_data.busy  = 1'b0;
            tbl_req.wr_data.start = cur_ff.start + OB'(size_ff);
            state_in              = S_SPLIT_CUR;
         end
         S_SPLIT_CUR: begin
            tbl_req.wr_en         = 1'b1;
            tbl_req.wr_addr       = idx_ff[IB-1:0];
            tbl_req.wr_data.len   = LB'(size_ff);
            tbl_req.wr_data.busy  = 1'b1;
            tbl_req.wr_data.start = cur_ff.start;
            count_in              = count_ff + CB'(1);
            granted_in            = 16'(cur_ff.start);
            status_in             = fsa_pkg::STATUS_OK;
            state_in              = S_DONE;
         end
         S_NEXT_EV: begin
            status_in = fsa_pkg::STATUS_OK;
            if (hi_next + CB'(1) == count_ff) begin
               // merged run reaches the table end, trim it away
               count_in = lo_ff;
               state_in = S_DONE;
            end else begin
               tbl_req.wr_en         = 1'b1;
               tbl_req.wr_addr       = lo_ff[IB-1:0];
               tbl_req.wr_data.len   = sum_next;
               tbl_req.wr_data.busy  = 1'b0;
               tbl_req.wr_data.start = lo_start_ff;
               dist_in               = 2'(hi_next - lo_ff);
               jdx_in                = hi_next + CB'(1);
               state_in              = (hi_next == lo_ff) ? S_DONE : S_SHD_RD;
            end
         end
         S_SHD_RD: begin
            if (jdx_ff == count_ff) begin
               count_in = count_ff - CB'(dist_ff);
               state_in = S_DONE;
            end else begin
               tbl_req.rd_addr = jdx_ff[IB-1:0];
               state_in        = S_SHD_WR;
            end
         end
         S_SHD_WR: begin
            tbl_req.wr_en   = 1'b1;
            tbl_req.wr_addr = IB'(jdx_ff - CB'(dist_ff));
            tbl_req.wr_data = rd_data;
            jdx_in          = jdx_ff + CB'(1);
            state_in        = S_SHD_RD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_granted_in = (status_ff == fsa_pkg::STATUS_OK) ? granted_ff : 16'd0;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      jdx_ff         <= jdx_in;
      lo_ff          <= lo_in;
      dist_ff        <= dist_in;
      func_ff        <= func_in;
      size_ff        <= size_in;
      ofs_ff         <= ofs_in;
      end_ff         <= end_in;
      cur_ff         <= cur_in;
      prev_busy_ff   <= prev_busy_in;
      prev_len_ff    <= prev_len_in;
      prev_start_ff  <= prev_start_in;
      sum_ff         <= sum_in;
      lo_start_ff    <= lo_start_in;
      status_ff      <= status_in;
      granted_ff     <= granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
   end
endmodule
`default_nettype wire

>>> hdl/first_fit_segment_allocator_unit.sv
// top level of the first-fit segment allocator with its register port
//
// Usage: a request word (req_func, req_alloc_size, req_free_offset) is taken
// on req_valid && req_ready. An allocate grants the first free segment that
// is large enough (splitting off the remainder) or appends a segment after
// the last one; a free releases the segment starting at req_free_offset and
// merges it with free neighbors. One response word (rsp_status,
// rsp_granted_offset) comes back per request on rsp_valid/rsp_ready.
// heap_size is written through the APB-style port at address 0; write it
// only while no request is in flight.
// The segment table has a single read port, so entries are scanned, and
// moved by a split or merge, one after another. One request is in work at
// a time; req_ready is high only while the sequencer is idle, so a new
// request is taken only after the previous response has been issued.
// Reset clears the segment count and heap_size returns to 65535. A stalled
// receiver holds the response; the finished next request then waits.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_segment_allocator_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic        req_func,
   input  wire logic [15:0] req_alloc_size,
   input  wire logic [15:0] req_free_offset,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [1:0]  rsp_status,
   output      logic [15:0] rsp_granted_offset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output      logic [31:0] prdata,
   output      logic        pready
);
   logic [fsa_pkg::HEAP_BITS-1:0] heap_ff, heap_in;
   fsa_pkg::tbl_req_type          tbl_req;
   fsa_pkg::entry_type            rd_data;
   logic                          reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = (paddr[2] == 1'b0);
   assign prdata  = reg_sel ? 32'(heap_ff) : 32'd0;

   always_comb begin
      heap_in = heap_ff;
      if (psel && penable && pwrite && reg_sel) begin
         heap_in = pwdata[fsa_pkg::HEAP_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_ff <= fsa_pkg::HEAP_RESET;
      end else begin
         heap_ff <= heap_in;
      end
   end

   fsa_seq u_seq (
      .clock              (clock),
      .reset              (reset),
      .heap_size          (heap_ff),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_alloc_size     (req_alloc_size),
      .req_free_offset    (req_free_offset),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_granted_offset (rsp_granted_offset),
      .tbl_req            (tbl_req),
      .rd_data            (rd_data)
   );

   fsa_table u_table (
      .clock   (clock),
      .tbl_req (tbl_req),
      .rd_data (rd_data)
   );
endmodule
`default_nettype wire

>>> hdl/fsa_checker.sv
// port checker for the allocator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module fsa_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_status,
   input wire logic [15:0] rsp_granted_offset,
   input wire logic        psel,
   input wire logic        pready
);
   // a refused request never reports an offset
   a_zero_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != fsa_pkg::STATUS_OK
      |-> rsp_granted_offset == 16'd0)
      else $error("nonzero offset on error status");

   // one request word in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after a request word was taken");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_granted_offset))
      else $error("stalled response word changed");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      psel |-> pready)
      else $error("register port not ready");
endmodule

bind first_fit_segment_allocator_unit fsa_checker u_fsa_checker (.*);
`default_nettype wire

>>> dv/tb_first_fit_segment_allocator_unit.sv
// testbench for the first-fit segment allocator with a table model predictor
`timescale 1ns / 1ps
module tb_first_fit_segment_allocator_unit;
   typedef struct packed {
      logic        func;
      logic [15:0] size;
      logic [15:0] ofs;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] granted;
   } rsp_word_type;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int STALL_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = fsa_pkg::FUNC_ALLOC;
   logic [15:0] req_alloc_size = '0;
   logic [15:0] req_free_offset = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_granted_offset;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   first_fit_segment_allocator_unit u_top (.*);

   // allocator model state
   logic [15:0] seg_len [fsa_pkg::MAX_SEGMENTS];
   logic        seg_busy [fsa_pkg::MAX_SEGMENTS];
   logic [15:0] seg_start [fsa_pkg::MAX_SEGMENTS];
   int          seg_count;
   logic [15:0] heap_limit;

   req_word_type pending_reqs [$];
   rsp_word_type expected_rsps [$];
   int          mismatches = 0;
   int          cycle_count = 0;
   bit          no_idle = 1'b0;
   bit          req_taken = 1'b0;
   bit          stall_arm = 1'b0;
   bit          stall_done = 1'b0;
   int          stall_cycles = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic void drop_seg(int k);
      for (int j = k; j + 1 < seg_count; j++) begin
         seg_len[j] = seg_len[j+1];
         seg_busy[j] = seg_busy[j+1];
         seg_start[j] = seg_start[j+1];
      end
      seg_count--;
   endfunction

   function automatic rsp_word_type predict_alloc(logic [15:0] size);
      rsp_word_type r;
      logic [16:0] seg_end;
      r = '{status: fsa_pkg::STATUS_OK, granted: '0};
      if (size == 16'd0) begin
         r.status = fsa_pkg::STATUS_NO_SPACE;
         return r;
      end
      for (int i = 0; i < seg_count; i++) begin
         if (!seg_busy[i] && seg_len[i] >= size) begin
            if (seg_len[i] > size) begin
               if (seg_count >= fsa_pkg::MAX_SEGMENTS) begin
                  r.status = fsa_pkg::STATUS_FULL;
                  return r;
               end
               for (int j = seg_count; j > i + 1; j--) begin
                  seg_len[j] = seg_len[j-1];
                  seg_busy[j] = seg_busy[j-1];
                  seg_start[j] = seg_start[j-1];
               end
               seg_len[i+1] = seg_len[i] - size;
               seg_busy[i+1] = 1'b0;
               seg_start[i+1] = seg_start[i] + size;
               seg_count++;
            end
            seg_busy[i] = 1'b1;
            seg_len[i] = size;
            r.granted = seg_start[i];
            return r;
         end
      end
      seg_end = '0;
      if (seg_count > 0)
         seg_end = {1'b0, seg_start[seg_count-1]} + {1'b0, seg_len[seg_count-1]};
      if ({1'b0, seg_end} + 18'(size) > {2'b0, heap_limit}) begin
         r.status = fsa_pkg::STATUS_NO_SPACE;
         return r;
      end
      if (seg_count >= fsa_pkg::MAX_SEGMENTS) begin
         r.status = fsa_pkg::STATUS_FULL;
         return r;
      end
      seg_len[seg_count] = size;
      seg_busy[seg_count] = 1'b1;
      seg_start[seg_count] = seg_end[15:0];
      seg_count++;
      r.granted = seg_end[15:0];
      return r;
   endfunction

   function automatic rsp_word_type predict_free(logic [15:0] ofs);
      rsp_word_type r;
      int i;
      r = '{status: fsa_pkg::STATUS_OK, granted: '0};
      for (i = 0; i < seg_count; i++)
         if (seg_start[i] == ofs) break;
      if (i >= seg_count) begin
         r.status = fsa_pkg::STATUS_NOT_FOUND;
         return r;
      end
      seg_busy[i] = 1'b0;
      if (i > 0 && !seg_busy[i-1]) begin
         seg_len[i-1] = seg_len[i-1] + seg_len[i];
         drop_seg(i);
         i--;
      end
      if (i + 1 < seg_count && !seg_busy[i+1]) begin
         seg_len[i] = seg_len[i] + seg_len[i+1];
         drop_seg(i + 1);
      end
      if (i + 1 == seg_count && !seg_busy[i])
         drop_seg(i);
      return r;
   endfunction

   // receiver stall counter
   always @(negedge clock) begin
      if (stall_arm && !stall_done) begin
         if (stall_cycles < STALL_CYCLES)
            stall_cycles <= stall_cycles + 1;
         else
            stall_done <= 1'b1;
      end
   end

   // driver
   always @(negedge clock) begin
      req_word_type w;
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_reqs.size() > 0 && (no_idle || $urandom_range(99) >= 22)) begin
               w = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_func <= w.func;
               req_alloc_size <= w.size;
               req_free_offset <= w.ofs;
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (stall_arm && !stall_done) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= no_idle || ($urandom_range(99) >= 22);
         end
      end
   end

   // prediction on acceptance
   always @(posedge clock) begin
      rsp_word_type p;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         if (req_func == fsa_pkg::FUNC_ALLOC)
            p = predict_alloc(req_alloc_size);
         else
            p = predict_free(req_free_offset);
         expected_rsps.insert(expected_rsps.size(), p);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: status %0d offset %0d",
                  rsp_status, rsp_granted_offset);
         end else begin
            rsp_word_type e;
            e = expected_rsps.pop_front();
            if (e.status !== rsp_status || e.granted !== rsp_granted_offset) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp status %0d offset %0d, got status %0d offset %0d",
                     e.status, e.granted, rsp_status, rsp_granted_offset);
            end
         end
      end
   end

   task automatic write_heap_size(logic [15:0] value);
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {16'b0, value};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      heap_limit = value;
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic void push_req(logic func, logic [15:0] size, logic [15:0] ofs);
      req_word_type w;
      w = '{func: func, size: size, ofs: ofs};
      pending_reqs.insert(pending_reqs.size(), w);
   endfunction

   function automatic logic [15:0] pick_size();
      case ($urandom_range(9))
         0: return 16'($urandom);
         1: return 16'($urandom_range(1, 4));
         default: return 16'($urandom_range(1, 3000));
      endcase
   endfunction

   function automatic logic [15:0] pick_free_ofs();
      // mostly a start the model knows; sometimes noise
      if (seg_count > 0 && $urandom_range(9) < 8)
         return seg_start[$urandom_range(seg_count - 1)];
      return 16'($urandom);
   endfunction

   initial begin
      heap_limit = fsa_pkg::HEAP_RESET;
      seg_count = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part
      push_req(fsa_pkg::FUNC_ALLOC, 16'd0, 16'hFFFF);
      push_req(fsa_pkg::FUNC_ALLOC, 16'hFFFF, 16'd0);
      push_req(fsa_pkg::FUNC_ALLOC, 16'd1, 16'd0);
      push_req(fsa_pkg::FUNC_FREE, 16'd0, 16'd0);
      push_req(fsa_pkg::FUNC_FREE, 16'd0, 16'hFFFF);
      for (int i = 0; i < 16; i++)
         push_req(fsa_pkg::FUNC_ALLOC, 16'd10, 16'd0);
      push_req(fsa_pkg::FUNC_ALLOC, 16'd1, 16'd0);
      push_req(fsa_pkg::FUNC_FREE, 16'hFFFF, 16'd20);
      push_req(fsa_pkg::FUNC_ALLOC, 16'd5, 16'd0);
      push_req(fsa_pkg::FUNC_FREE, 16'd0, 16'd20);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_heap_size(16'd1);
            1: write_heap_size(16'd500);
            2: write_heap_size(16'hFFFF);
            3: write_heap_size(16'd4000);
            4: write_heap_size(16'($urandom_range(1, 65535)));
            default: write_heap_size(16'd20000);
         endcase
         no_idle = (phase == 2);
         if (phase == 3) begin
            // long receiver stall while the sender keeps offering
            stall_arm = 1'b1;
         end
         for (int n = 0; n < 220; n++) begin
            // predictor state is advanced on acceptance, so draw from it loosely
            if ($urandom_range(99) < 55)
               push_req(fsa_pkg::FUNC_ALLOC, pick_size(), 16'($urandom));
            else
               push_req(fsa_pkg::FUNC_FREE, 16'($urandom), pick_free_ofs());
            if (pending_reqs.size() > 4)
               while (pending_reqs.size() > 2) @(posedge clock);
         end
         drain();
      end

      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

>>> filelist.f
hdl/fsa_pkg.sv
hdl/fsa_table.sv
hdl/fsa_seq.sv
hdl/first_fit_segment_allocator_unit.sv
hdl/fsa_checker.sv
dv/tb_first_fit_segment_allocator_unit.sv
